@@ rtl/sliding_window_median_unit_defines.svh @@
// assertion helpers for the sliding window median unit
`ifndef SLIDING_WINDOW_MEDIAN_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_UNIT_DEFINES_SVH

// same-cycle implication
`define SWM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("swm assertion failed");

// next-cycle implication
`define SWM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("swm assertion failed");

`endif

@@ rtl/swm_pkg.sv @@
`timescale 1ns / 1ps

package swm_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int DATA_W     = 32;
    localparam int IDX_W      = $clog2(MAX_WINDOW);
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
    localparam int AGE_W      = IDX_W;
    localparam int GRP        = 8;
    localparam int NGRP       = (MAX_WINDOW + GRP - 1) / GRP;

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic [AGE_W-1:0]         age;
        logic                     gt;
        logic                     ge;
    } t_swm_link;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample;
        logic signed [DATA_W-1:0] old;
        logic                     full;
        logic                     upd;
        logic [CNT_W-1:0]         win;
        logic [CNT_W-1:0]         fill;
    } t_swm_ctl;

    localparam t_swm_link LINK_LEFT_EDGE  = '{val: '0, age: '0, gt: 1'b0, ge: 1'b0};
    localparam t_swm_link LINK_RIGHT_EDGE = '{val: '0, age: '0, gt: 1'b1, ge: 1'b1};

endpackage

@@ rtl/swm_ram.sv @@
`timescale 1ns / 1ps

module swm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/swm_cell.sv @@
`timescale 1ns / 1ps

module swm_cell import swm_pkg::*; (
    input  logic             i_clk,
    input  logic [IDX_W-1:0] i_idx,
    input  t_swm_ctl         i_ctl,
    input  t_swm_link        i_left,
    input  t_swm_link        i_right,
    output t_swm_link        o_link
);

    logic signed [DATA_W-1:0] r_val;
    logic signed [DATA_W-1:0] n_val;
    logic [AGE_W-1:0]         r_age;
    logic [AGE_W-1:0]         n_age;
    logic [CNT_W-1:0]         idx_ext;
    logic                     valid;
    logic                     en;
    logic                     gt;
    logic                     ge;

    assign idx_ext = {1'b0, i_idx};
    assign valid   = i_ctl.full ? (idx_ext < i_ctl.win) : (idx_ext < i_ctl.fill);
    assign en      = i_ctl.full ? valid : (idx_ext <= i_ctl.fill);

    // ordering key is (value, age): new sample sorts ahead of equal values
    assign gt = valid ? (r_val >= i_ctl.sample) : 1'b1;
    assign ge = i_ctl.full && valid &&
                ((r_val > i_ctl.old) ||
                 ((r_val == i_ctl.old) && ({1'b0, r_age} == i_ctl.win - CNT_W'(1))));

    always_comb begin
        n_val = r_val;
        n_age = r_age;
        if (i_ctl.upd && en) begin
            n_age = r_age + AGE_W'(1);
            if (!ge) begin
                if (gt) begin
                    if (i_left.gt) begin
                        n_val = i_left.val;
                        n_age = i_left.age + AGE_W'(1);
                    end else begin
                        n_val = i_ctl.sample;
                        n_age = '0;
                    end
                end
            end else begin
                priority if (!i_right.gt) begin
                    n_val = i_right.val;
                    n_age = i_right.age + AGE_W'(1);
                end else if (!i_left.ge && i_left.gt) begin
                    n_val = i_left.val;
                    n_age = i_left.age + AGE_W'(1);
                end else if (!i_left.ge || !gt) begin
                    n_val = i_ctl.sample;
                    n_age = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_age <= n_age;
    end

    assign o_link = '{val: r_val, age: r_age, gt: gt, ge: ge};

endmodule

@@ rtl/sliding_window_median_unit.sv @@
`timescale 1ns / 1ps
`include "sliding_window_median_unit_defines.svh"

// Running lower median over the last window_size samples (1..64; 0 acts as 1, larger
// values saturate at 64). A write to window_size restarts the window. The sorted window
// lives in a row of 64 cells that each compare against the new sample and the sample
// leaving the window and shift with their neighbors in the update state; the leaving
// sample is read from an arrival-order RAM. Each sample is accepted and updates the cells;
// one that gives a result then passes a two-stage registered selection of the median
// cell into the output register, which waits while the output is held. No result is
// given until window_size samples have arrived; after that every sample gives one.
module sliding_window_median_unit import swm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [CNT_W-1:0]         i_window_size,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [DATA_W-1:0] i_sample,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [DATA_W-1:0] o_median
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_UPD  = 4'b0010,
        ST_RED1 = 4'b0100,
        ST_RED2 = 4'b1000
    } t_state;

    t_state                   r_state;
    t_state                   n_state;
    logic [CNT_W-1:0]         r_win;
    logic [CNT_W-1:0]         n_win;
    logic [CNT_W-1:0]         r_fill;
    logic [CNT_W-1:0]         n_fill;
    logic [IDX_W-1:0]         r_ptr;
    logic [IDX_W-1:0]         n_ptr;
    logic signed [DATA_W-1:0] r_sample;
    logic signed [DATA_W-1:0] r_grp [NGRP];
    logic signed [DATA_W-1:0] n_grp [NGRP];
    logic                     r_out_valid;
    logic                     n_out_valid;
    logic signed [DATA_W-1:0] r_median;
    logic signed [DATA_W-1:0] n_median;

    logic                     full;
    logic                     accept;
    logic                     out_free;
    logic [CNT_W-1:0]         win_m1;
    logic [IDX_W-1:0]         med_idx;
    logic [IDX_W-1:0]         ram_waddr;
    logic [DATA_W-1:0]        ram_rdata;
    t_swm_ctl                 ctl;
    t_swm_link                w_link [MAX_WINDOW];
    logic signed [DATA_W-1:0] w_val  [MAX_WINDOW];

    assign full     = (r_fill == r_win);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign win_m1   = r_win - CNT_W'(1);
    assign med_idx  = IDX_W'(win_m1 >> 1);
    assign ram_waddr = full ? r_ptr : r_fill[IDX_W-1:0];

    swm_ram #(
        .WIDTH(DATA_W),
        .DEPTH(MAX_WINDOW)
    ) u_arrival (
        .i_clk  (i_clk),
        .i_we   (r_state == ST_UPD),
        .i_waddr(ram_waddr),
        .i_wdata(r_sample),
        .i_raddr(r_ptr),
        .o_rdata(ram_rdata)
    );

    assign ctl = '{sample: r_sample, old: $signed(ram_rdata), full: full,
                   upd: (r_state == ST_UPD), win: r_win, fill: r_fill};

    for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
        t_swm_link w_l;
        t_swm_link w_r;
        if (i == 0) begin : g_first
            assign w_l = LINK_LEFT_EDGE;
        end else begin : g_mid_l
            assign w_l = w_link[i-1];
        end
        if (i == MAX_WINDOW - 1) begin : g_last
            assign w_r = LINK_RIGHT_EDGE;
        end else begin : g_mid_r
            assign w_r = w_link[i+1];
        end
        swm_cell u_cell (
            .i_clk  (i_clk),
            .i_idx  (IDX_W'(i)),
            .i_ctl  (ctl),
            .i_left (w_l),
            .i_right(w_r),
            .o_link (w_link[i])
        );
        assign w_val[i] = w_link[i].val;
    end

    // first stage of the median select: one or-group per eight cells
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp[g] = '0;
            for (int j = 0; j < GRP; j++) begin
                if ((g * GRP + j < MAX_WINDOW) && (g * GRP + j == int'(med_idx))) begin
                    n_grp[g] = n_grp[g] | w_val[g * GRP + j];
                end
            end
        end
    end

    always_comb begin
        n_median = r_median;
        if (r_state == ST_RED2 && out_free) begin
            n_median = '0;
            for (int g = 0; g < NGRP; g++) begin
                n_median = n_median | r_grp[g];
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_win       = r_win;
        n_fill      = r_fill;
        n_ptr       = r_ptr;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cfg_wr_en) begin
            priority if (i_window_size == '0) begin
                n_win = CNT_W'(1);
            end else if (i_window_size > CNT_W'(MAX_WINDOW)) begin
                n_win = CNT_W'(MAX_WINDOW);
            end else begin
                n_win = i_window_size;
            end
            n_fill = '0;
            n_ptr  = '0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                if (full) begin
                    n_ptr   = ({1'b0, r_ptr} + CNT_W'(1) == r_win) ? '0 : r_ptr + IDX_W'(1);
                    n_state = ST_RED1;
                end else begin
                    n_fill  = r_fill + CNT_W'(1);
                    n_state = (r_fill + CNT_W'(1) == r_win) ? ST_RED1 : ST_IDLE;
                end
            end
            ST_RED1: begin
                n_state = ST_RED2;
            end
            ST_RED2: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_win       <= CNT_W'(1);
            r_fill      <= '0;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_win       <= n_win;
            r_fill      <= n_fill;
            r_ptr       <= n_ptr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= i_sample;
        end
        if (r_state == ST_RED1) begin
            r_grp <= n_grp;
        end
        r_median <= n_median;
    end

    assign o_ready  = (r_state == ST_IDLE);
    assign o_valid  = r_out_valid;
    assign o_median = r_median;

    `SWM_ASSERT_IMP(a_fill_in_window, 1'b1, r_fill <= r_win)
    `SWM_ASSERT_IMP(a_ptr_in_window, 1'b1, {1'b0, r_ptr} < r_win)
    `SWM_ASSERT_NXT(a_accept_updates, accept, r_state == ST_UPD)
    `SWM_ASSERT_NXT(a_result_loaded, r_state == ST_RED2 && out_free, o_valid && o_ready)

endmodule

@@ dv/tb_sliding_window_median_unit.sv @@
`timescale 1ns / 1ps

module tb_sliding_window_median_unit;
    import swm_pkg::*;

    localparam logic signed [DATA_W-1:0] SAMPLE_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] SAMPLE_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_HOLD     = 150;
    localparam int TAIL_CYCLES   = 20;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_wr_en = 1'b0;
    logic [CNT_W-1:0]         i_window_size = '0;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic signed [DATA_W-1:0] i_sample = '0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic signed [DATA_W-1:0] o_median;

    logic signed [DATA_W-1:0] pending_samples[$];
    logic signed [DATA_W-1:0] window_fifo[$];
    logic signed [DATA_W-1:0] window_sorted[$];
    logic signed [DATA_W-1:0] expected_medians[$];
    int  window_len = 1;
    bit  sample_taken = 1'b0;
    bit  quiet_tail = 1'b0;
    int  send_gap = 0;
    int  hold_count = 0;
    int  hold_requests = 0;
    int  holds_done = 0;
    int  samples_queued = 0;
    int  samples_accepted = 0;
    int  medians_checked = 0;
    int  window_settings = 0;
    int  failures = 0;

    sliding_window_median_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_window_size (i_window_size),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_sample      (i_sample),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_median      (o_median)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int clamp_window(input logic [CNT_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_WINDOW)
            return MAX_WINDOW;
        return int'(v);
    endfunction

    // slide the window by one sample and queue the lower median once it is full
    task automatic slide_window(input logic signed [DATA_W-1:0] s);
        logic signed [DATA_W-1:0] leaving;
        int pos;
        if (window_fifo.size() == window_len) begin
            leaving = window_fifo.pop_front();
            pos = 0;
            while (pos < window_sorted.size() && window_sorted[pos] != leaving)
                pos++;
            window_sorted.delete(pos);
        end
        window_fifo.push_back(s);
        pos = 0;
        while (pos < window_sorted.size() && window_sorted[pos] <= s)
            pos++;
        window_sorted.insert(pos, s);
        if (window_fifo.size() == window_len)
            expected_medians.push_back(window_sorted[(window_len + 1) / 2 - 1]);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_sample();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind <= 5)
            return $urandom;
        if (kind <= 7)
            return $signed($urandom_range(0, 6)) - 3;
        case ($urandom_range(0, 5))
            0: return SAMPLE_MIN;
            1: return SAMPLE_MAX;
            2: return SAMPLE_MIN + 1;
            3: return SAMPLE_MAX - 1;
            4: return 0;
            default: return -1;
        endcase
    endfunction

    task automatic queue_sample(input logic signed [DATA_W-1:0] s);
        pending_samples.push_back(s);
        samples_queued++;
    endtask

    task automatic queue_random(input int count);
        repeat (count) queue_sample(pick_sample());
    endtask

    task automatic wait_drained();
        while (pending_samples.size() > 0 || i_valid || expected_medians.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [CNT_W-1:0] v);
        wait_drained();
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_window_size <= v;
        @(posedge i_clk);
        window_len = clamp_window(v);
        window_fifo.delete();
        window_sorted.delete();
        window_settings++;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // input side: sample transaction accepted
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            slide_window(i_sample);
            samples_accepted++;
            sample_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || sample_taken) begin
            sample_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (pending_samples.size() > 0 && !quiet_tail &&
                         $urandom_range(0, 7) == 0) begin
                send_gap = $urandom_range(0, 4);
                i_valid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
                i_valid <= 1'b1;
                i_sample <= pending_samples.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_count > 0) begin
            hold_count--;
            i_ready <= 1'b0;
        end else if (holds_done < hold_requests) begin
            holds_done++;
            hold_count = LONG_HOLD - 1;
            i_ready <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            hold_count = $urandom_range(0, 4);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // output side: median transaction accepted
    always @(posedge i_clk) begin
        logic signed [DATA_W-1:0] want;
        if (i_rst_n && o_valid && i_ready) begin
            medians_checked++;
            if (expected_medians.size() == 0) begin
                $error("median: no result expected, actual %0d", o_median);
                failures++;
            end else begin
                want = expected_medians.pop_front();
                if (o_median !== want) begin
                    $error("median: expected %0d, actual %0d", want, o_median);
                    failures++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("sliding_window_median_unit regression: fail");
        $finish;
    end

    initial begin
        int start;
        int win;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset window of one sample
        queue_sample(SAMPLE_MIN);
        queue_sample(SAMPLE_MAX);
        queue_sample(0);
        queue_sample(-1);

        write_window(3);
        queue_sample(5);
        queue_sample(5);
        queue_sample(5);
        queue_sample(SAMPLE_MAX);
        queue_sample(SAMPLE_MIN);
        queue_sample(0);
        queue_sample(-1);
        queue_sample(7);
        queue_sample(7);

        // zero acts as a window of one
        write_window(0);
        queue_sample(1);
        queue_sample(SAMPLE_MIN);

        write_window(2);
        queue_sample(SAMPLE_MAX);
        queue_sample(SAMPLE_MIN);
        queue_sample(3);
        queue_sample(3);

        // partial window, then restart by a write
        write_window(4);
        queue_sample(1);
        queue_sample(2);

        // saturates to the largest window; long output stall once results flow
        write_window(127);
        start = samples_accepted;
        queue_random(90);
        while (samples_accepted < start + MAX_WINDOW + 2)
            @(posedge i_clk);
        hold_requests++;

        write_window(MAX_WINDOW);
        queue_random(70);

        while (samples_queued < 480) begin
            if ($urandom_range(0, 5) == 0) begin
                win = $urandom_range(10, 70);
                write_window(CNT_W'(win));
                queue_random(clamp_window(CNT_W'(win)) + $urandom_range(0, 20));
            end else begin
                win = $urandom_range(1, 9);
                write_window(CNT_W'(win));
                queue_random(win + $urandom_range(0, 40));
            end
        end

        write_window(5);
        quiet_tail = 1'b1;
        queue_random(70);

        while (pending_samples.size() > 0 || i_valid || expected_medians.size() > 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("fed %0d samples over %0d window settings (1 to 64, zero and saturated)",
                 samples_accepted, window_settings);
        $display("checked %0d medians with random stalls on both sides and one long hold",
                 medians_checked);
        if (failures == 0)
            $display("sliding_window_median_unit regression: pass");
        else
            $display("sliding_window_median_unit regression: fail");
        $finish;
    end

endmodule
